// ===== src/mdsp_pkg.sv =====
// mdsp_pkg: shared types and constants of the feedback-queue dispatcher
// no dependencies
package mdsp_pkg;

  localparam int NUM_LEVELS = 3;
  localparam int MAX_JOBS   = 16;
  localparam int TIME_BITS  = 12;
  localparam int JOB_BITS   = $clog2(MAX_JOBS);
  localparam int LVL_BITS   = $clog2(NUM_LEVELS);
  localparam int CNT_BITS   = $clog2(MAX_JOBS + 1);
  localparam int FIFO_DEPTH = NUM_LEVELS * MAX_JOBS;
  localparam int FIFO_AW    = LVL_BITS + JOB_BITS;
  localparam int STEP_BITS  = 8;

  localparam logic [CNT_BITS-1:0]  CNT_FULL = CNT_BITS'(MAX_JOBS);
  localparam logic [LVL_BITS-1:0]  LVL_LAST = LVL_BITS'(NUM_LEVELS - 1);
  localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

  // operation codes
  localparam logic [1:0] OP_ADMIT    = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_IO_DONE  = 2'd2;

  // outcome codes
  localparam logic [2:0] OUT_IDLE     = 3'd0;
  localparam logic [2:0] OUT_FINISHED = 3'd1;
  localparam logic [2:0] OUT_TO_IO    = 3'd2;
  localparam logic [2:0] OUT_DEMOTED  = 3'd3;
  localparam logic [2:0] OUT_QUEUED   = 3'd4;
  localparam logic [2:0] OUT_REFUSED  = 3'd5;

  // register indexes
  localparam logic [1:0] CFG_QUANTUM0 = 2'd0;
  localparam logic [1:0] CFG_QUANTUM1 = 2'd1;
  localparam logic [1:0] CFG_QUANTUM2 = 2'd2;
  localparam logic [1:0] CFG_BOOST    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_BOOST_RD, S_BOOST_WR, S_PICK, S_RUN, S_QUEUE, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic boost_rd;
    logic boost_wr;
    logic pick_rd;
    logic run_exec;
    logic queue;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       boost_due;
    logic       move_avail;
    logic       any_queued;
    logic       out_free;
  } status_t;

endpackage

// ===== src/mdsp_ram.sv =====
// mdsp_ram: generic single-write, single-read RAM with registered read
// no dependencies
module mdsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mdsp_ctrl.sv =====
// mdsp_ctrl: sequencing state machine of the dispatcher
// depends on mdsp_pkg
module mdsp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mdsp_pkg::status_t sts,
  output mdsp_pkg::cmd_t    cmd
);
  import mdsp_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        priority if (sts.op == OP_ADMIT || sts.op == OP_IO_DONE) begin
          state_next = S_QUEUE;
        end else if (sts.op == OP_DISPATCH) begin
          state_next = sts.boost_due ? S_BOOST_RD : S_PICK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_BOOST_RD: begin
        if (sts.move_avail) begin
          cmd.boost_rd = 1'b1;
          state_next   = S_BOOST_WR;
        end else begin
          state_next = S_PICK;
        end
      end
      S_BOOST_WR: begin
        cmd.boost_wr = 1'b1;
        state_next   = S_BOOST_RD;
      end
      S_PICK: begin
        if (sts.any_queued) begin
          cmd.pick_rd = 1'b1;
          state_next  = S_RUN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RUN: begin
        cmd.run_exec = 1'b1;
        state_next   = S_DONE;
      end
      S_QUEUE: begin
        cmd.queue  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a request is only taken while idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  // a load always leads to decoding
  a_load_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_DECODE) else $error("load without decode");
  // a boost write always follows a boost read
  a_boost_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.boost_rd |=> cmd.boost_wr) else $error("boost read without write");

endmodule

// ===== src/mdsp_datapath.sv =====
// mdsp_datapath: queue storage, job times, configuration and result register
// depends on mdsp_pkg and mdsp_ram
module mdsp_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic [1:0]                     operation,
  input  logic [mdsp_pkg::JOB_BITS-1:0]  job_id,
  input  logic [mdsp_pkg::TIME_BITS-1:0] job_time,
  input  logic                           io_wait,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     outcome,
  output logic [mdsp_pkg::JOB_BITS-1:0]  run_job,
  output logic [7:0]                     run_time,
  output logic [1:0]                     new_level,
  output logic                           boosted,
  input  mdsp_pkg::cmd_t                 cmd,
  output mdsp_pkg::status_t              sts
);
  import mdsp_pkg::*;

  // configuration
  logic [7:0] quantum0, quantum1, quantum2, boost_period;
  // captured request
  logic [1:0]           item_op;
  logic [JOB_BITS-1:0]  item_id;
  logic [TIME_BITS-1:0] item_time;
  logic                 item_io;
  // scheduler state
  logic [JOB_BITS-1:0]  head [NUM_LEVELS];
  logic [CNT_BITS-1:0]  count [NUM_LEVELS];
  logic [TIME_BITS-1:0] remaining [MAX_JOBS];
  logic [STEP_BITS-1:0] step_counter;
  logic [LVL_BITS-1:0]  cur_lv;
  // result staging
  logic [2:0]          res_outcome;
  logic [JOB_BITS-1:0] res_job;
  logic [7:0]          res_time;
  logic [1:0]          res_level;
  logic                res_boosted;

  logic                ram_we;
  logic [FIFO_AW-1:0]  ram_waddr, ram_raddr;
  logic [JOB_BITS-1:0] ram_wdata, ram_rdata;

  logic [LVL_BITS-1:0]  src_lv, pick_lv, demote_lv;
  logic                 src_found, pick_found;
  logic [7:0]           quantum_raw, quantum;
  logic [TIME_BITS-1:0] rem_j, rem_new;
  logic [7:0]           slice;
  logic                 full0;

  mdsp_ram #(.WIDTH(JOB_BITS), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // boost source and dispatch level searches
  always_comb begin
    src_lv     = LVL_LAST;
    src_found  = 1'b0;
    pick_lv    = '0;
    pick_found = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (count[l] != '0) begin
        pick_lv    = LVL_BITS'(l);
        pick_found = 1'b1;
        if (l != 0) begin
          src_lv    = LVL_BITS'(l);
          src_found = 1'b1;
        end
      end
    end
  end

  assign full0 = count[0] == CNT_FULL;

  // slice length for the level just popped
  always_comb begin
    unique case (cur_lv)
      LVL_BITS'(0): quantum_raw = quantum0;
      LVL_BITS'(1): quantum_raw = quantum1;
      default:      quantum_raw = quantum2;
    endcase
    quantum   = (quantum_raw == '0) ? 8'd1 : quantum_raw;
    rem_j     = remaining[ram_rdata];
    slice     = (rem_j < TIME_BITS'(quantum)) ? 8'(rem_j) : quantum;
    rem_new   = rem_j - TIME_BITS'(slice);
    demote_lv = (cur_lv < LVL_LAST) ? cur_lv + 1'b1 : LVL_LAST;
    if (count[demote_lv] == CNT_FULL) begin
      demote_lv = cur_lv;
    end
  end

  // fifo memory ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {LVL_BITS'(0), JOB_BITS'(head[0] + count[0][JOB_BITS-1:0])};
    ram_wdata = ram_rdata;
    ram_raddr = cmd.boost_rd ? {src_lv, head[src_lv]} : {pick_lv, head[pick_lv]};
    priority if (cmd.boost_wr) begin
      ram_we = 1'b1;
    end else if (cmd.queue) begin
      ram_we    = !full0;
      ram_wdata = item_id;
    end else if (cmd.run_exec) begin
      ram_we    = (rem_new != '0) && !item_io;
      ram_waddr = {demote_lv, JOB_BITS'(head[demote_lv] + count[demote_lv][JOB_BITS-1:0])};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum0     <= 8'd2;
      quantum1     <= 8'd4;
      quantum2     <= 8'd8;
      boost_period <= 8'd20;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_QUANTUM0: quantum0     <= cfg_data;
        CFG_QUANTUM1: quantum1     <= cfg_data;
        CFG_QUANTUM2: quantum2     <= cfg_data;
        CFG_BOOST:    boost_period <= cfg_data;
        default:      ;
      endcase
    end
  end

  // request capture and job times
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op   <= operation;
      item_id   <= job_id;
      item_time <= job_time;
      item_io   <= io_wait;
    end
    if (cmd.queue && !full0 && item_op == OP_ADMIT) begin
      remaining[item_id] <= item_time;
    end
    if (cmd.run_exec) begin
      remaining[ram_rdata] <= rem_new;
    end
    if (cmd.pick_rd) begin
      cur_lv <= pick_lv;
    end
  end

  // queue heads, counts and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l]  <= '0;
        count[l] <= '0;
      end
      step_counter <= '0;
    end else begin
      if (cmd.decode && item_op == OP_DISPATCH) begin
        if (step_counter >= boost_period) begin
          step_counter <= STEP_BITS'(1);
        end else if (step_counter != STEP_MAX) begin
          step_counter <= step_counter + 1'b1;
        end
      end
      priority if (cmd.boost_rd) begin
        head[src_lv]  <= head[src_lv] + 1'b1;
        count[src_lv] <= count[src_lv] - 1'b1;
      end else if (cmd.pick_rd) begin
        head[pick_lv]  <= head[pick_lv] + 1'b1;
        count[pick_lv] <= count[pick_lv] - 1'b1;
      end else if (cmd.boost_wr || (cmd.queue && !full0)) begin
        count[0] <= count[0] + 1'b1;
      end else if (cmd.run_exec && rem_new != '0 && !item_io) begin
        count[demote_lv] <= count[demote_lv] + 1'b1;
      end
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_outcome <= OUT_IDLE;
      res_job     <= '0;
      res_time    <= '0;
      res_level   <= '0;
      res_boosted <= 1'b0;
    end
    if (cmd.decode && item_op == OP_DISPATCH) begin
      res_boosted <= step_counter >= boost_period;
    end
    if (cmd.queue) begin
      res_job     <= item_id;
      res_outcome <= full0 ? OUT_REFUSED : OUT_QUEUED;
    end
    if (cmd.run_exec) begin
      res_job  <= ram_rdata;
      res_time <= slice;
      priority if (rem_new == '0) begin
        res_outcome <= OUT_FINISHED;
        res_level   <= 2'(cur_lv);
      end else if (item_io) begin
        res_outcome <= OUT_TO_IO;
        res_level   <= 2'(cur_lv);
      end else begin
        res_outcome <= OUT_DEMOTED;
        res_level   <= 2'(demote_lv);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      outcome   <= res_outcome;
      run_job   <= res_job;
      run_time  <= res_time;
      new_level <= res_level;
      boosted   <= res_boosted;
    end
  end

  // status towards the controller
  assign sts.op         = item_op;
  assign sts.boost_due  = step_counter >= boost_period;
  assign sts.move_avail = src_found && !full0;
  assign sts.any_queued = pick_found;
  assign sts.out_free   = !out_valid || out_ready;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready)) else $error("result overwritten");
  // level 0 never overflows during a boost
  a_boost_room: assert property (@(posedge clk) disable iff (rst)
    cmd.boost_rd |-> !full0) else $error("boost into full level");
  // no level count exceeds the job count
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count[0] <= CNT_FULL && count[1] <= CNT_FULL && count[LVL_LAST] <= CNT_FULL)
    else $error("count overflow");

endmodule

// ===== src/mlfq_dispatcher.sv =====
// mlfq_dispatcher: top level of the three-level feedback-queue scheduler
// depends on mdsp_pkg, mdsp_ctrl, mdsp_datapath and mdsp_ram
//
// Requests arrive on in_valid/in_ready with operation, job_id,
// job_time and io_wait; one result per request leaves on
// out_valid/out_ready with outcome, run_job, run_time, new_level, boosted.
// Quanta and boost interval are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not
// enforce this. Admit and I/O-complete requests pass the decode, queue and
// done states before the result is registered; a dispatch passes decode,
// pick, run and done (no run when nothing is queued). A boost adds a boost
// read state and a read and write per job moved, one at a time through the
// single read and write port of the queue memory. Only one request is in
// flight; the next is taken once its result sits in the output register.
// Reset empties all queues, clears the step counter and loads the default
// quanta 2, 4, 8 and boost interval 20. Job times are undefined until a
// job is admitted. While the receiver stalls a finished result waits in
// the output register and the following request stalls in its last state.
module mlfq_dispatcher (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     operation,
  input  logic [mdsp_pkg::JOB_BITS-1:0]  job_id,
  input  logic [mdsp_pkg::TIME_BITS-1:0] job_time,
  input  logic                           io_wait,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     outcome,
  output logic [mdsp_pkg::JOB_BITS-1:0]  run_job,
  output logic [7:0]                     run_time,
  output logic [1:0]                     new_level,
  output logic                           boosted
);
  import mdsp_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // sequencer
  mdsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and arithmetic
  mdsp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .operation (operation),
    .job_id    (job_id),
    .job_time  (job_time),
    .io_wait   (io_wait),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .outcome   (outcome),
    .run_job   (run_job),
    .run_time  (run_time),
    .new_level (new_level),
    .boosted   (boosted),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
